[src/psd_pkg.sv]
package psd_pkg;

    // Fraction bits of the projection quotient.
    localparam int FRAC_T = 16;

    // Width of the distance result.
    localparam int DIST_BITS = 17;

    // Width and values of the nearest-point case code.
    localparam int CODE_W = 2;
    localparam logic [CODE_W-1:0] CASE_START  = 2'd0;
    localparam logic [CODE_W-1:0] CASE_END    = 2'd1;
    localparam logic [CODE_W-1:0] CASE_INSIDE = 2'd2;

endpackage

[src/psd_if.sv]
// Query word: point and segment endpoints.
interface psd_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                    input ready);
    modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  output ready);
endinterface

// Result word: distance and case code.
interface psd_out_if;
    logic                                valid;
    logic                                ready;
    logic [psd_pkg::DIST_BITS-1:0]       distance;
    logic [psd_pkg::CODE_W-1:0]          nearest_case;

    modport source (output valid, distance, nearest_case, input ready);
    modport sink (input valid, distance, nearest_case, output ready);
endinterface

[src/psd_stage.sv]
// One registered pipeline stage with valid/ready flow control.
module psd_stage #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // The stage loads when it is empty or its word moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end
endmodule

[src/psd_div_cell.sv]
// One restoring division step: yields one quotient bit per cell.
module psd_div_cell #(
    parameter int LW   = 35,
    parameter int SIDE = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [LW-1:0]   in_rem,
    input  logic [LW-1:0]   in_den,
    input  logic [psd_pkg::FRAC_T-1:0] in_q,
    input  logic [SIDE-1:0] in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [LW-1:0]   out_rem,
    output logic [LW-1:0]   out_den,
    output logic [psd_pkg::FRAC_T-1:0] out_q,
    output logic [SIDE-1:0] out_side
);
    logic            valid_reg;
    logic [LW-1:0]   rem_reg;
    logic [LW-1:0]   den_reg;
    logic [psd_pkg::FRAC_T-1:0] q_reg;
    logic [SIDE-1:0] side_reg;
    logic [LW-1:0]   shifted;
    logic            take;
    logic [LW-1:0]   rem_next;
    logic [psd_pkg::FRAC_T-1:0] q_next;

    // Shift, trial subtract, keep the bit.
    always_comb
    begin
        shifted  = {in_rem[LW-2:0], 1'b0};
        take     = shifted >= in_den;
        rem_next = take ? shifted - in_den : shifted;
        q_next   = {in_q[psd_pkg::FRAC_T-2:0], take};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end
endmodule

[src/psd_sqrt_cell.sv]
// One digit step of the integer square root; the cell's bit weight is fixed.
module psd_sqrt_cell #(
    parameter int SW   = 38,
    parameter int STEP = 0,
    parameter int RB   = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [SW-1:0] in_num,
    input  logic [SW-1:0] in_res,
    input  logic [psd_pkg::CODE_W-1:0] in_code,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [SW-1:0] out_num,
    output logic [SW-1:0] out_res,
    output logic [psd_pkg::CODE_W-1:0] out_code
);
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (RB - 1 - STEP));

    logic          valid_reg;
    logic [SW-1:0] num_reg;
    logic [SW-1:0] res_reg;
    logic [psd_pkg::CODE_W-1:0] code_reg;
    logic [SW-1:0] trial;
    logic [SW-1:0] num_next;
    logic [SW-1:0] res_next;

    // Subtract the trial value where it fits and set the root bit.
    always_comb
    begin
        trial = in_res + BIT;
        if (in_num >= trial)
        begin
            num_next = in_num - trial;
            res_next = (in_res >> 1) + BIT;
        end
        else
        begin
            num_next = in_num;
            res_next = in_res >> 1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_res   = res_reg;
    assign out_code  = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            num_reg  <= num_next;
            res_reg  <= res_next;
            code_reg <= in_code;
        end
    end
endmodule

[src/point_segment_distance_top.sv]
// Channel   Dir  Word
// in        in   point_x, point_y, start_x, start_y, end_x, end_y (signed Q8.8)
// out       out  distance (unsigned Q9.8), nearest_case
//
// One query enters per cycle unless a stall on out backs up to in; a result passes
// through six registered arithmetic stages, FRAC_T divider cells, and COORD_WIDTH + 3
// square-root cells.
// rst_n clears all valid bits at once; payload registers are not reset.
// A stall on out holds, in the same cycle, each full stage that has only full stages
// after it; other stages keep moving and loading, so bubbles are squeezed out.
module point_segment_distance_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    psd_in_if.sink   in,
    psd_out_if.source out
);
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int LW   = 2 * W + 3;
    localparam int FT   = psd_pkg::FRAC_T;
    localparam int CW   = psd_pkg::CODE_W;
    localparam int TW   = FT + 2;
    localparam int MW   = TW + DW;
    localparam int XW   = W + 3;
    localparam int QW   = 2 * XW;
    localparam int SW   = 2 * W + 6;
    localparam int RB   = W + 3;
    localparam int SIDE = CW + 1 + 4 * DW;

    // Stage A: coordinate differences.
    localparam int A_W = 6 * DW;
    logic [A_W-1:0] a_in, a_out;
    logic a_valid, a_ready;
    logic signed [DW-1:0] ax_c, ay_c, cx_c, cy_c, ex_c, ey_c;

    always_comb
    begin
        ax_c = DW'(in.point_x) - DW'(in.start_x);
        ay_c = DW'(in.point_y) - DW'(in.start_y);
        cx_c = DW'(in.end_x) - DW'(in.start_x);
        cy_c = DW'(in.end_y) - DW'(in.start_y);
        ex_c = DW'(in.point_x) - DW'(in.end_x);
        ey_c = DW'(in.point_y) - DW'(in.end_y);
        a_in = {ax_c, ay_c, cx_c, cy_c, ex_c, ey_c};
    end

    psd_stage #(.WIDTH(A_W)) u_sa (
        .clk, .rst_n, .in_valid(in.valid), .in_ready(in.ready), .in_data(a_in),
        .out_valid(a_valid), .out_ready(a_ready), .out_data(a_out)
    );

    // Stage B: the four products.
    localparam int B_W = 4 * PW + A_W;
    logic [B_W-1:0] b_in, b_out;
    logic b_valid, b_ready;
    logic signed [DW-1:0] ax_a, ay_a, cx_a, cy_a;

    always_comb
    begin
        {ax_a, ay_a, cx_a, cy_a} = a_out[A_W-1:2*DW];
        b_in = {PW'(ax_a * cx_a), PW'(ay_a * cy_a), PW'(cx_a * cx_a),
                PW'(cy_a * cy_a), a_out};
    end

    psd_stage #(.WIDTH(B_W)) u_sb (
        .clk, .rst_n, .in_valid(a_valid), .in_ready(a_ready), .in_data(b_in),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_out)
    );

    // Stage C: dot, squared length and case choice.
    logic signed [PW-1:0] pxc, pyc, pcc, pdd;
    logic signed [DW-1:0] ax_b, ay_b, cx_b, cy_b, ex_b, ey_b;
    logic signed [LW-1:0] dot, len_sq;
    logic [CW-1:0]        code_c;
    logic                 one_c;
    logic signed [DW-1:0] dx0_c, dy0_c;
    logic [LW-1:0]        num_c;
    logic [SIDE-1:0]      side_c;

    always_comb
    begin
        {pxc, pyc, pcc, pdd, ax_b, ay_b, cx_b, cy_b, ex_b, ey_b} = b_out;
        dot    = LW'(pxc) + LW'(pyc);
        len_sq = LW'(pcc) + LW'(pdd);
        one_c  = 1'b0;
        num_c  = '0;
        dx0_c  = ax_b;
        dy0_c  = ay_b;
        if (len_sq == '0 || dot < 0)
        begin
            code_c = psd_pkg::CASE_START;
        end
        else if (dot > len_sq)
        begin
            code_c = psd_pkg::CASE_END;
            dx0_c  = ex_b;
            dy0_c  = ey_b;
        end
        else
        begin
            code_c = psd_pkg::CASE_INSIDE;
            one_c  = (dot == len_sq);
            num_c  = dot;
        end
        side_c = {code_c, one_c, dx0_c, dy0_c, cx_b, cy_b};
    end

    // Divider cells, one quotient bit each.
    logic            dv_valid [FT+1];
    logic            dv_ready [FT+1];
    logic [LW-1:0]   dv_rem   [FT+1];
    logic [LW-1:0]   dv_den   [FT+1];
    logic [FT-1:0]   dv_q     [FT+1];
    logic [SIDE-1:0] dv_side  [FT+1];

    assign dv_valid[0] = b_valid;
    assign b_ready     = dv_ready[0];
    assign dv_rem[0]   = num_c;
    assign dv_den[0]   = len_sq;
    assign dv_q[0]     = '0;
    assign dv_side[0]  = side_c;

    for (genvar k = 0; k < FT; k++)
    begin : g_div
        psd_div_cell #(.LW(LW), .SIDE(SIDE)) u_cell (
            .clk, .rst_n,
            .in_valid(dv_valid[k]), .in_ready(dv_ready[k]),
            .in_rem(dv_rem[k]), .in_den(dv_den[k]), .in_q(dv_q[k]),
            .in_side(dv_side[k]),
            .out_valid(dv_valid[k+1]), .out_ready(dv_ready[k+1]),
            .out_rem(dv_rem[k+1]), .out_den(dv_den[k+1]), .out_q(dv_q[k+1]),
            .out_side(dv_side[k+1])
        );
    end

    // Stage D: projection times the segment vector.
    localparam int D_W = CW + 2 * DW + 2 * MW;
    logic [D_W-1:0] d_in, d_out;
    logic d_valid, d_ready;
    logic [CW-1:0]        code_d;
    logic                 one_d;
    logic signed [DW-1:0] dx0_d, dy0_d, cx_d, cy_d;
    logic signed [TW-1:0] t_d;

    always_comb
    begin
        {code_d, one_d, dx0_d, dy0_d, cx_d, cy_d} = dv_side[FT];
        if (one_d)
        begin
            t_d = TW'(1) << FT;
        end
        else if (code_d == psd_pkg::CASE_INSIDE)
        begin
            t_d = TW'(dv_q[FT]);
        end
        else
        begin
            t_d = '0;
        end
        d_in = {code_d, dx0_d, dy0_d, MW'(t_d * cx_d), MW'(t_d * cy_d)};
    end

    psd_stage #(.WIDTH(D_W)) u_sd (
        .clk, .rst_n, .in_valid(dv_valid[FT]), .in_ready(dv_ready[FT]), .in_data(d_in),
        .out_valid(d_valid), .out_ready(d_ready), .out_data(d_out)
    );

    // Stage E: offset from the nearest point, floored.
    localparam int E_W = CW + 2 * XW;
    logic [E_W-1:0] e_in, e_out;
    logic e_valid, e_ready;
    logic [CW-1:0]        code_e;
    logic signed [DW-1:0] dx0_e, dy0_e;
    logic signed [MW-1:0] mx_e, my_e;
    logic signed [MW-1:0] fx_e, fy_e;

    always_comb
    begin
        {code_e, dx0_e, dy0_e, mx_e, my_e} = d_out;
        fx_e = mx_e >>> FT;
        fy_e = my_e >>> FT;
        e_in = {code_e, XW'(XW'(dx0_e) - XW'(fx_e)), XW'(XW'(dy0_e) - XW'(fy_e))};
    end

    psd_stage #(.WIDTH(E_W)) u_se (
        .clk, .rst_n, .in_valid(d_valid), .in_ready(d_ready), .in_data(e_in),
        .out_valid(e_valid), .out_ready(e_ready), .out_data(e_out)
    );

    // Stage F: squares.
    localparam int F_W = CW + 2 * QW;
    logic [F_W-1:0] f_in, f_out;
    logic f_valid, f_ready;
    logic [CW-1:0]        code_f;
    logic signed [XW-1:0] dx_f, dy_f;

    always_comb
    begin
        {code_f, dx_f, dy_f} = e_out;
        f_in = {code_f, QW'(dx_f * dx_f), QW'(dy_f * dy_f)};
    end

    psd_stage #(.WIDTH(F_W)) u_sf (
        .clk, .rst_n, .in_valid(e_valid), .in_ready(e_ready), .in_data(f_in),
        .out_valid(f_valid), .out_ready(f_ready), .out_data(f_out)
    );

    // Stage G: sum of squares.
    localparam int G_W = CW + SW;
    logic [G_W-1:0] g_in, g_out;
    logic g_valid, g_ready;
    logic [CW-1:0] code_g;
    logic [QW-1:0] sqx_g, sqy_g;

    always_comb
    begin
        {code_g, sqx_g, sqy_g} = f_out;
        g_in = {code_g, SW'(sqx_g) + SW'(sqy_g)};
    end

    psd_stage #(.WIDTH(G_W)) u_sg (
        .clk, .rst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(g_in),
        .out_valid(g_valid), .out_ready(g_ready), .out_data(g_out)
    );

    // Square-root cells, one root bit each; the last one drives the output.
    logic          sq_valid [RB+1];
    logic          sq_ready [RB+1];
    logic [SW-1:0] sq_num   [RB+1];
    logic [SW-1:0] sq_res   [RB+1];
    logic [CW-1:0] sq_code  [RB+1];

    assign sq_valid[0] = g_valid;
    assign g_ready     = sq_ready[0];
    assign sq_num[0]   = g_out[SW-1:0];
    assign sq_res[0]   = '0;
    assign sq_code[0]  = g_out[G_W-1:SW];

    for (genvar k = 0; k < RB; k++)
    begin : g_sqrt
        psd_sqrt_cell #(.SW(SW), .STEP(k), .RB(RB)) u_cell (
            .clk, .rst_n,
            .in_valid(sq_valid[k]), .in_ready(sq_ready[k]),
            .in_num(sq_num[k]), .in_res(sq_res[k]), .in_code(sq_code[k]),
            .out_valid(sq_valid[k+1]), .out_ready(sq_ready[k+1]),
            .out_num(sq_num[k+1]), .out_res(sq_res[k+1]), .out_code(sq_code[k+1])
        );
    end

    assign out.valid        = sq_valid[RB];
    assign sq_ready[RB]     = out.ready;
    assign out.distance     = sq_res[RB][psd_pkg::DIST_BITS-1:0];
    assign out.nearest_case = sq_code[RB];
endmodule

[src/psd_checker.sv]
// Port-level checks on the result channel.
module psd_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic [psd_pkg::DIST_BITS-1:0] distance,
    input logic [psd_pkg::CODE_W-1:0]    nearest_case
);
    // A stalled word stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled word does not change.
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(distance) && $stable(nearest_case))
        else $error("result word changed while stalled");

    // Only the three defined cases appear.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nearest_case == psd_pkg::CASE_START ||
                       nearest_case == psd_pkg::CASE_END ||
                       nearest_case == psd_pkg::CASE_INSIDE))
        else $error("undefined case code");

    // No word is offered while reset is held.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");
endmodule

bind point_segment_distance_top psd_checker u_psd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out.valid),
    .out_ready(out.ready),
    .distance(out.distance),
    .nearest_case(out.nearest_case)
);
